>>> design/fcq_pkg.sv
// ----------------------------------------------------------------------------
// fcq_pkg
// Shared types, codes and field layout for the frame-committed event queue.
// ----------------------------------------------------------------------------
package fcq_pkg;

    // Default ring depth
    localparam int DEF_QUEUE_DEPTH = 64;

    // Field widths
    localparam int MODE_W   = 2;
    localparam int ID_W     = 8;
    localparam int KIND_W   = 3;
    localparam int COORD_W  = 16;
    localparam int FORCE_W  = 32;

    // Item word: id, kind, x, y, force from the low bit up
    localparam int ITEM_W   = ID_W + KIND_W + 2 * COORD_W + FORCE_W;
    localparam int TDATA_W  = ((ITEM_W + 7) / 8) * 8;
    localparam int S_USER_W = MODE_W;
    localparam int M_USER_W = 2;

    // Bit offsets inside the item word
    localparam int ID_LSB    = 0;
    localparam int KIND_LSB  = ID_LSB + ID_W;
    localparam int X_LSB     = KIND_LSB + KIND_W;
    localparam int Y_LSB     = X_LSB + COORD_W;
    localparam int FORCE_LSB = Y_LSB + COORD_W;

    // Operation codes carried on s_tuser
    localparam logic [MODE_W-1:0] MODE_PUSH = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FLIP = 2'd1;
    localparam logic [MODE_W-1:0] MODE_POP  = 2'd2;

    // Controller states
    typedef enum logic [0:0] {
        ST_IDLE = 1'b0,
        ST_RESP = 1'b1
    } fcq_state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;     // a word was taken, refresh result flags
        logic push_wr;  // write entry and advance record pointer
        logic flip;     // commit the frame
        logic pop_rd;   // read entry and advance read pointer
    } fcq_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
    } fcq_status_t;

endpackage

>>> design/fcq_ctrl.sv
// ----------------------------------------------------------------------------
// fcq_ctrl
// Handshake controller: takes one word, issues its command, holds the result.
// ----------------------------------------------------------------------------
module fcq_ctrl
    import fcq_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [MODE_W-1:0] s_mode,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  fcq_status_t       status,
    output fcq_cmd_t          cmd
);

    fcq_state_t state_reg;
    fcq_state_t state_next;
    logic       take;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next  = state_reg;
        s_tready    = 1'b0;
        m_tvalid    = 1'b0;
        take        = 1'b0;
        cmd         = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                take     = s_tvalid;
                if (take) begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        // decode the operation of the taken word
        cmd.load    = take;
        cmd.push_wr = take && (s_mode == MODE_PUSH) && !status.full;
        cmd.flip    = take && (s_mode == MODE_FLIP);
        cmd.pop_rd  = take && (s_mode == MODE_POP) && !status.empty;
    end

endmodule

>>> design/fcq_dpath.sv
// ----------------------------------------------------------------------------
// fcq_dpath
// Pointers, event stores and result registers of the event queue.
// ----------------------------------------------------------------------------
module fcq_dpath
    import fcq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
)
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [TDATA_W-1:0]  s_tdata,
    input  fcq_cmd_t            cmd,
    output fcq_status_t         status,
    output logic [TDATA_W-1:0]  m_tdata,
    output logic [M_USER_W-1:0] m_tuser
);

    localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CRD_W   = 2 * COORD_W;
    localparam int ATTR_W  = ID_W + KIND_W + FORCE_W;
    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(QUEUE_DEPTH - 1);

    // Event stores
    logic [CRD_W-1:0]  coord_mem [QUEUE_DEPTH];
    logic [ATTR_W-1:0] attr_mem  [QUEUE_DEPTH];

    logic [PTR_W-1:0]  record_ptr_reg;
    logic [PTR_W-1:0]  commit_ptr_reg;
    logic [PTR_W-1:0]  region_ptr_reg;
    logic [PTR_W-1:0]  read_ptr_reg;
    logic [PTR_W-1:0]  record_ptr_next;
    logic [PTR_W-1:0]  read_ptr_next;

    logic [CRD_W-1:0]  coord_rd_reg;
    logic [ATTR_W-1:0] attr_rd_reg;
    logic              accepted_reg;
    logic              item_valid_reg;

    logic [CRD_W-1:0]  coord_wr;
    logic [ATTR_W-1:0] attr_wr;

    // Write words from the input item
    assign coord_wr = {s_tdata[Y_LSB +: COORD_W], s_tdata[X_LSB +: COORD_W]};
    assign attr_wr  = {s_tdata[FORCE_LSB +: FORCE_W], s_tdata[KIND_LSB +: KIND_W],
                       s_tdata[ID_LSB +: ID_W]};

    // Ring increments
    assign record_ptr_next = (record_ptr_reg == LAST_IDX) ? '0 : record_ptr_reg + 1'b1;
    assign read_ptr_next   = (read_ptr_reg == LAST_IDX) ? '0 : read_ptr_reg + 1'b1;

    // Status: full only when the previous frame still holds entries
    assign status.full  = (region_ptr_reg != commit_ptr_reg) &&
                          (record_ptr_reg == region_ptr_reg);
    assign status.empty = (read_ptr_reg == commit_ptr_reg);

    // Pointer registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            record_ptr_reg <= '0;
            commit_ptr_reg <= '0;
            region_ptr_reg <= '0;
            read_ptr_reg   <= '0;
            accepted_reg   <= 1'b0;
            item_valid_reg <= 1'b0;
        end else begin
            if (cmd.push_wr) begin
                record_ptr_reg <= record_ptr_next;
            end
            if (cmd.flip) begin
                commit_ptr_reg <= record_ptr_reg;
                region_ptr_reg <= commit_ptr_reg;
            end
            if (cmd.pop_rd) begin
                read_ptr_reg <= read_ptr_next;
            end
            if (cmd.load) begin
                accepted_reg   <= cmd.push_wr;
                item_valid_reg <= cmd.pop_rd;
            end
        end
    end

    // Store write port
    always_ff @(posedge aclk) begin
        if (cmd.push_wr) begin
            coord_mem[record_ptr_reg] <= coord_wr;
            attr_mem[record_ptr_reg]  <= attr_wr;
        end
    end

    // Store read port, registered
    always_ff @(posedge aclk) begin
        if (cmd.pop_rd) begin
            coord_rd_reg <= coord_mem[read_ptr_reg];
            attr_rd_reg  <= attr_mem[read_ptr_reg];
        end
    end

    // Result word; item fields read as zero unless a pop returned an entry
    always_comb begin
        m_tdata = '0;
        if (item_valid_reg) begin
            m_tdata[ID_LSB +: ID_W]       = attr_rd_reg[0 +: ID_W];
            m_tdata[KIND_LSB +: KIND_W]   = attr_rd_reg[ID_W +: KIND_W];
            m_tdata[FORCE_LSB +: FORCE_W] = attr_rd_reg[ID_W + KIND_W +: FORCE_W];
            m_tdata[X_LSB +: COORD_W]     = coord_rd_reg[0 +: COORD_W];
            m_tdata[Y_LSB +: COORD_W]     = coord_rd_reg[COORD_W +: COORD_W];
        end
    end

    assign m_tuser = {item_valid_reg, accepted_reg};

endmodule

>>> design/frame_committed_event_queue_top.sv
// ----------------------------------------------------------------------------
// frame_committed_event_queue_top
// Ring of pointer events released to the reader one committed frame at a time.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one operation word; s_tuser selects push (0),
//   flip (1) or pop (2), code 3 does nothing. A push stores the event in
//   s_tdata at the record pointer, a flip commits the frame recorded so far,
//   a pop returns the oldest committed event.
//   Every taken word yields exactly one result word on the master channel:
//   m_tuser[0] is set for a stored push, m_tuser[1] for a pop that returned
//   an event, and m_tdata then carries that event (zero otherwise).
//   Latency: the result is valid in the cycle after the word is taken.
//   Flow: the block takes no new word until the receiver has taken the
//   result of the last one; the handshake controller holds one word in
//   flight, and the read port of the event store is registered.
//   When the receiver stalls, the result word holds and s_tready stays low.
//   Reset clears all pointers and drops any pending result; the event
//   store itself is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module frame_committed_event_queue_top
    import fcq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
)
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // touch_id, event_kind, pos_x, pos_y, force_bits, zero pad
    input  logic [TDATA_W-1:0]  s_tdata,
    // mode
    input  logic [S_USER_W-1:0] s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // out_touch_id, out_event_kind, out_x, out_y, out_force_bits, zero pad
    output logic [TDATA_W-1:0]  m_tdata,
    // accepted, item_valid
    output logic [M_USER_W-1:0] m_tuser
);

    fcq_cmd_t    cmd;
    fcq_status_t status;

    // Handshake controller
    fcq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_mode   (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Pointers and event stores
    fcq_dpath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .cmd     (cmd),
        .status  (status),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

endmodule

>>> design/fcq_checker.sv
// ----------------------------------------------------------------------------
// fcq_checker
// Port-level checks of the event queue, bound to the top level.
// ----------------------------------------------------------------------------
module fcq_checker
    import fcq_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [TDATA_W-1:0]  m_tdata,
    input logic [M_USER_W-1:0] m_tuser
);

    // Stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // A taken word yields its result in the next cycle
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("no result after a taken word");

    // Only one word in flight
    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input taken while a result is pending");

    // A push result and a pop result never coincide; no event without a pop hit
    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]) && (m_tuser[1] || m_tdata == '0))
        else $error("inconsistent result flags");

endmodule

bind frame_committed_event_queue_top fcq_checker u_fcq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the frame-committed event queue. A directed table
// covers field extremes, every operation, empty pops, idle codes and a
// double flip. A random phase follows, built from whole frames (pushes,
// flip, pops), overwrite bursts after an empty frame, pop bursts and noise.
// Every result word is checked against a cycle-free model of the ring.
// ----------------------------------------------------------------------------
module tb;
    import fcq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH      = DEF_QUEUE_DEPTH;
    localparam int RAND_ITEMS = 600;
    localparam int HOLD_AT    = 120;   // result words before the long stall
    localparam int HOLD_LEN   = 300;   // cycles of the long stall
    localparam int IDLE_PCT   = 23;
    localparam int N_DIR      = 21;

    // tuser code that the block ignores
    localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;

    // One event, laid out as on tdata (touch id in the low bits)
    typedef struct packed {
        logic [FORCE_W-1:0]        frc;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
        logic [KIND_W-1:0]         kind;
        logic [ID_W-1:0]           id;
    } touch_ev_t;

    typedef struct packed {
        logic      accepted;
        logic      item_valid;
        touch_ev_t ev;
    } ring_reply_t;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [ID_W-1:0]    id;
        logic [KIND_W-1:0]  kind;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [FORCE_W-1:0] frc;
        logic               typed;   // reply given below, not predicted
        logic               acc;
        logic               vld;
    } dir_row_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [TDATA_W-1:0]  s_tdata = '0;
    logic [S_USER_W-1:0] s_tuser = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [TDATA_W-1:0]  m_tdata;
    logic [M_USER_W-1:0] m_tuser;

    frame_committed_event_queue_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Ring model state
    touch_ev_t   ring_mem [DEPTH];
    int          rec_ptr, cmt_ptr, rgn_ptr, rd_ptr;
    ring_reply_t replies_due [$];

    int  mismatches = 0;
    int  n_items    = 0;    // words sent, idle codes excluded
    int  words_out  = 0;    // result words taken
    int  hold_left  = 0;
    bit  hold_done  = 1'b0;
    bit  calm       = 1'b0; // no idling on either side

    // Directed table; typed rows carry their reply, others use the model
    dir_row_t dir_rows [N_DIR] = '{
        // pop and flip right after reset, idle code with all ones
        '{MODE_POP,  8'h00, 3'd0, 16'h0000, 16'h0000, 32'h00000000, 1'b1, 1'b0, 1'b0},
        '{MODE_FLIP, 8'h00, 3'd0, 16'h0000, 16'h0000, 32'h00000000, 1'b1, 1'b0, 1'b0},
        '{MODE_NONE, 8'hff, 3'd7, 16'hffff, 16'hffff, 32'hffffffff, 1'b1, 1'b0, 1'b0},
        // field extremes
        '{MODE_PUSH, 8'hff, 3'd7, 16'h8000, 16'h7fff, 32'hffffffff, 1'b1, 1'b1, 1'b0},
        '{MODE_PUSH, 8'h00, 3'd0, 16'h7fff, 16'h8000, 32'h00000000, 1'b1, 1'b1, 1'b0},
        // nothing committed yet
        '{MODE_POP,  8'h00, 3'd0, 16'h0000, 16'h0000, 32'h00000000, 1'b1, 1'b0, 1'b0},
        '{MODE_PUSH, 8'h5a, 3'd3, 16'hffff, 16'h0001, 32'h3f800000, 1'b1, 1'b1, 1'b0},
        '{MODE_FLIP, 8'h00, 3'd0, 16'h0000, 16'h0000, 32'h00000000, 1'b1, 1'b0, 1'b0},
        '{MODE_POP,  8'h00, 3'd0, 16'h0000, 16'h0000, 32'h00000000, 1'b0, 1'b0, 1'b0},
        '{MODE_NONE, 8'h12, 3'd5, 16'h1234, 16'h5678, 32'h9abcdef0, 1'b1, 1'b0, 1'b0},
        '{MODE_POP,  8'hff, 3'd7, 16'hffff, 16'hffff, 32'hffffffff, 1'b0, 1'b0, 1'b0},
        // pushed into the next frame while its predecessor drains
        '{MODE_PUSH, 8'ha5, 3'd4, 16'h0000, 16'hffff, 32'h80000000, 1'b1, 1'b1, 1'b0},
        '{MODE_POP,  8'h00, 3'd0, 16'h0000, 16'h0000, 32'h00000000, 1'b0, 1'b0, 1'b0},
        // read pointer has met the commit pointer
        '{MODE_POP,  8'h00, 3'd0, 16'h0000, 16'h0000, 32'h00000000, 1'b1, 1'b0, 1'b0},
        '{MODE_FLIP, 8'h00, 3'd0, 16'h0000, 16'h0000, 32'h00000000, 1'b1, 1'b0, 1'b0},
        '{MODE_POP,  8'h00, 3'd0, 16'h0000, 16'h0000, 32'h00000000, 1'b0, 1'b0, 1'b0},
        '{MODE_POP,  8'h00, 3'd0, 16'h0000, 16'h0000, 32'h00000000, 1'b1, 1'b0, 1'b0},
        // second flip with no pushes leaves the previous region empty
        '{MODE_FLIP, 8'h00, 3'd0, 16'h0000, 16'h0000, 32'h00000000, 1'b1, 1'b0, 1'b0},
        '{MODE_PUSH, 8'h01, 3'd1, 16'h0001, 16'hfffe, 32'h7f7fffff, 1'b1, 1'b1, 1'b0},
        '{MODE_FLIP, 8'h00, 3'd0, 16'h0000, 16'h0000, 32'h00000000, 1'b1, 1'b0, 1'b0},
        '{MODE_POP,  8'h00, 3'd0, 16'h0000, 16'h0000, 32'h00000000, 1'b0, 1'b0, 1'b0}
    };

    // Apply one operation to the ring model and return its reply
    function automatic ring_reply_t ring_apply(input logic [MODE_W-1:0] mode,
                                               input touch_ev_t ev);
        ring_reply_t r;
        int          old_cmt;
        r = '0;
        case (mode)
            MODE_PUSH: begin
                // refused only when the previous frame still holds entries
                if (!(rgn_ptr != cmt_ptr && rec_ptr == rgn_ptr)) begin
                    ring_mem[rec_ptr] = ev;
                    rec_ptr = (rec_ptr + 1) % DEPTH;
                    r.accepted = 1'b1;
                end
            end
            MODE_FLIP: begin
                old_cmt = cmt_ptr;
                cmt_ptr = rec_ptr;
                rgn_ptr = old_cmt;
            end
            MODE_POP: begin
                if (rd_ptr != cmt_ptr) begin
                    r.item_valid = 1'b1;
                    r.ev = ring_mem[rd_ptr];
                    rd_ptr = (rd_ptr + 1) % DEPTH;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic touch_ev_t rand_event();
        touch_ev_t ev;
        ev.id   = ID_W'($urandom);
        ev.kind = KIND_W'($urandom);
        ev.x    = COORD_W'($urandom);
        ev.y    = COORD_W'($urandom);
        ev.frc  = $urandom;
        return ev;
    endfunction

    // Offer one word, wait for the handshake, then log its reply
    task automatic offer_word(input logic [MODE_W-1:0] mode, input touch_ev_t ev,
                              input bit typed, input ring_reply_t fixed);
        ring_reply_t want;
        calm <= (n_items >= 250 && n_items < 350);
        if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {{(TDATA_W - ITEM_W){1'b0}}, ev};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        want = ring_apply(mode, ev);
        if (typed) want = fixed;
        replies_due.push_back(want);
        if (mode != MODE_NONE) n_items++;
    endtask

    task automatic offer_rand(input logic [MODE_W-1:0] mode);
        offer_word(mode, rand_event(), 1'b0, '0);
    endtask

    task automatic note_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        mismatches++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    endtask

    // Clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // Long receiver stall, counted here once enough results have passed
    always @(posedge aclk) begin
        if (!hold_done && words_out >= HOLD_AT) begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Result side: check each word, then pick next cycle's ready
    always @(posedge aclk) begin : result_side
        ring_reply_t want;
        touch_ev_t   got;
        if (aresetn && m_tvalid && m_tready) begin
            got = touch_ev_t'(m_tdata[ITEM_W-1:0]);
            if (replies_due.size() == 0) begin
                mismatches++;
                $display("%0t: result word with none expected, tuser %0h tdata %0h",
                         $time, m_tuser, m_tdata);
            end else begin
                want = replies_due.pop_front();
                if (m_tuser[0] !== want.accepted)
                    note_mismatch("accepted", want.accepted, m_tuser[0]);
                if (m_tuser[1] !== want.item_valid)
                    note_mismatch("item_valid", want.item_valid, m_tuser[1]);
                if (got.id !== want.ev.id)
                    note_mismatch("out_touch_id", want.ev.id, got.id);
                if (got.kind !== want.ev.kind)
                    note_mismatch("out_event_kind", want.ev.kind, got.kind);
                if (got.x !== want.ev.x)
                    note_mismatch("out_x", want.ev.x, got.x);
                if (got.y !== want.ev.y)
                    note_mismatch("out_y", want.ev.y, got.y);
                if (got.frc !== want.ev.frc)
                    note_mismatch("out_force_bits", want.ev.frc, got.frc);
                if (m_tdata[TDATA_W-1:ITEM_W] !== '0)
                    note_mismatch("tdata pad", 0, m_tdata[TDATA_W-1:ITEM_W]);
            end
            words_out <= words_out + 1;
        end
        if (hold_left != 0)
            m_tready <= 1'b0;
        else if (calm)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Run limit
    initial begin
        #3_000_000;
        $display("simulation failed");
        $finish;
    end

    // Stimulus
    initial begin
        touch_ev_t   ev;
        ring_reply_t fixed;
        int          sel, n, m, base;
        bit          drained;
        drained = 1'b0;
        rec_ptr = 0;
        cmt_ptr = 0;
        rgn_ptr = 0;
        rd_ptr  = 0;
        foreach (ring_mem[i]) ring_mem[i] = '0;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        foreach (dir_rows[i]) begin
            ev.id   = dir_rows[i].id;
            ev.kind = dir_rows[i].kind;
            ev.x    = dir_rows[i].x;
            ev.y    = dir_rows[i].y;
            ev.frc  = dir_rows[i].frc;
            fixed = '0;
            fixed.accepted   = dir_rows[i].acc;
            fixed.item_valid = dir_rows[i].vld;
            offer_word(dir_rows[i].mode, ev, dir_rows[i].typed, fixed);
        end

        // random phase
        base = n_items;
        while (n_items - base < RAND_ITEMS) begin
            if (!drained && n_items - base >= 450) begin
                // sender pause until every result is back
                s_tvalid <= 1'b0;
                do @(posedge aclk); while (replies_due.size() != 0);
                drained = 1'b1;
            end
            sel = $urandom_range(0, 99);
            if (sel < 55) begin
                // one frame; a long one runs into the full condition
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 70)
                                                : $urandom_range(0, 8);
                repeat (n) offer_rand(MODE_PUSH);
                offer_rand(MODE_FLIP);
                m = $urandom_range(0, n + 2);
                repeat (m) offer_rand(MODE_POP);
            end else if (sel < 65) begin
                // empty previous region, then pushes that may overwrite
                offer_rand(MODE_FLIP);
                offer_rand(MODE_FLIP);
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 70)
                                                : $urandom_range(0, 6);
                repeat (n) offer_rand(MODE_PUSH);
            end else if (sel < 80) begin
                repeat ($urandom_range(1, 6)) offer_rand(MODE_POP);
            end else begin
                offer_rand(MODE_W'($urandom_range(0, 3)));
            end
        end
        s_tvalid <= 1'b0;

        while (replies_due.size() != 0) @(posedge aclk);
        repeat (5) @(posedge aclk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
